// ----- rtl/closed_polyline_line_normal_top_macros.svh -----
// assertion macros for the polyline normal block
`ifndef CLOSED_POLYLINE_LINE_NORMAL_TOP_MACROS_SVH
`define CLOSED_POLYLINE_LINE_NORMAL_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define CPLN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication checked in the next cycle
`define CPLN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/cpln_pkg.sv -----
// package: payload types and constants of the polyline normal block
package cpln_pkg;
  localparam int COORD_BITS_DEF  = 24;
  localparam int NORMAL_BITS_DEF = 16;
  localparam int OUT_BITS        = 16;
  localparam logic [OUT_BITS-1:0] UNIT_Q14 = 16'd16384;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0]  point_x;
    logic signed [COORD_BITS_DEF-1:0]  point_y;
    logic signed [COORD_BITS_DEF-1:0]  point_z;
    logic signed [NORMAL_BITS_DEF-1:0] surf_nx;
    logic signed [NORMAL_BITS_DEF-1:0] surf_ny;
    logic signed [NORMAL_BITS_DEF-1:0] surf_nz;
    logic                              final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] edge_nx;
    logic signed [OUT_BITS-1:0] edge_ny;
    logic signed [OUT_BITS-1:0] edge_nz;
    logic                       degenerate;
    logic                       end_of_line;
  } out_item_t;
endpackage

// ----- rtl/closed_polyline_line_normal_top.sv -----
// top level: closed polyline line normal, sequential datapath with serial units
// One input transaction is taken at a time. A point yields its normal when the
// next point arrives; the last point of a longer line yields two. Each normal is
// built by a sequencer: six serial multiplies side by side, one edge bit a cycle,
// a normalizing shift one bit a cycle, three squares, a bit-pair square root and
// three restoring divides (one quotient bit a cycle). A zero cross product skips
// the squares, root and divides. A final point that closes a longer line costs
// two results back to back. The output register holds a finished result while
// the next one is being computed.
module closed_polyline_line_normal_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpln_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cpln_pkg::out_item_t out_data
);
  import cpln_pkg::*;
  `include "closed_polyline_line_normal_top_macros.svh"

  localparam int COORD_BITS  = COORD_BITS_DEF;
  localparam int NORMAL_BITS = NORMAL_BITS_DEF;
  localparam int EW  = COORD_BITS + 1;          // edge width
  localparam int PW  = EW + NORMAL_BITS;        // product width
  localparam int CW  = PW + 1;                  // cross width
  localparam int MW  = 64;
  localparam int NW  = 30;                      // normalized magnitude width
  localparam int MCW = $clog2(MW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUB, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic                          have_prev, pend_last, fin_hold;
  logic signed [COORD_BITS-1:0]  fp [3];
  logic signed [COORD_BITS-1:0]  pp [3];
  logic signed [NORMAL_BITS-1:0] pn [3];
  logic signed [COORD_BITS-1:0]  cp [3];
  logic signed [NORMAL_BITS-1:0] cn [3];
  logic signed [EW-1:0]          ev [3];
  logic signed [NORMAL_BITS-1:0] nv [3];
  logic                          cur_eol;

  // serial multipliers: six products a*b, shift-add on multiplier bits
  logic [PW-1:0]      pacc [6];
  logic [PW-1:0]      mcand [6];
  logic [EW-1:0]      mplier [6];
  logic [MCW-1:0]     cnt;
  logic signed [CW-1:0] cr [3];
  logic [MW-1:0]      mag [3];
  logic               neg [3];
  logic [MW-1:0]      mmax;
  logic [MW-1:0]      l2;
  logic [1:0]         idx;
  logic [MW-1:0]      rem, root, bit4;
  logic [MW-1:0]      dnum, drem;
  logic [OUT_BITS:0]  quo;
  logic [OUT_BITS-1:0] res [3];
  logic               deg;
  logic               ov;
  out_item_t          obuf;

  assign in_ready  = (state == S_IDLE) && !pend_last;
  assign out_valid = ov;
  assign out_data  = obuf;

  // magnitudes of edge and normal for unsigned serial multiply
  function automatic logic [EW-1:0] abs_e(input logic signed [EW-1:0] v);
    abs_e = v[EW-1] ? EW'(-v) : EW'(v);
  endfunction
  function automatic logic [PW-1:0] abs_n(input logic signed [NORMAL_BITS-1:0] v);
    logic signed [NORMAL_BITS:0] w;
    w = {v[NORMAL_BITS-1], v};
    abs_n = w[NORMAL_BITS] ? PW'(-w) : PW'(w);
  endfunction

  // product index k -> (edge index, normal index): c0=e1n2-e2n1 etc
  localparam int EI [6] = '{1, 2, 2, 0, 0, 1};
  localparam int NI [6] = '{2, 1, 0, 2, 1, 0};

  logic signed [CW-1:0] prod [6];
  logic [2*NW-1:0]      sq;
  logic [MW-1:0]        trial;
  logic [MW-1:0]        dsub;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prod[k] = (ev[EI[k]][EW-1] ^ nv[NI[k]][NORMAL_BITS-1]) ?
                -CW'(signed'({1'b0, pacc[k]})) : CW'(signed'({1'b0, pacc[k]}));
    end
    sq    = mag[idx][NW-1:0] * mag[idx][NW-1:0];
    trial = root + bit4;
    dsub  = {drem[MW-2:0], dnum[MW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      pend_last <= 1'b0;
      ov        <= 1'b0;
      fin_hold  <= 1'b0;
    end else begin
      if (ov && out_ready && state != S_OUT) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pend_last) begin
            // second result of a final point
            for (int i = 0; i < 3; i++) begin
              ev[i] <= EW'(fp[i]) - EW'(cp[i]);
              nv[i] <= cn[i];
            end
            cur_eol   <= 1'b1;
            pend_last <= 1'b0;
            cnt       <= '0;
            state     <= S_MUL;
          end else if (in_valid) begin
            for (int i = 0; i < 3; i++) begin
              cp[i] <= (i == 0) ? in_data.point_x[COORD_BITS-1:0] :
                       (i == 1) ? in_data.point_y[COORD_BITS-1:0] :
                                  in_data.point_z[COORD_BITS-1:0];
              cn[i] <= (i == 0) ? in_data.surf_nx[NORMAL_BITS-1:0] :
                       (i == 1) ? in_data.surf_ny[NORMAL_BITS-1:0] :
                                  in_data.surf_nz[NORMAL_BITS-1:0];
            end
            fin_hold <= in_data.final_point;
            state    <= S_SUB;
          end
        end
        S_SUB: begin
          if (!have_prev) fp <= cp;
          if (have_prev) begin
            for (int i = 0; i < 3; i++) begin
              ev[i] <= EW'(cp[i]) - EW'(pp[i]);
              nv[i] <= pn[i];
            end
            cur_eol   <= 1'b0;
            pend_last <= fin_hold;
            cnt       <= '0;
            state     <= S_MUL;
          end else if (fin_hold) begin
            for (int i = 0; i < 3; i++) begin
              ev[i] <= '0;
              nv[i] <= cn[i];
            end
            cur_eol <= 1'b1;
            cnt     <= '0;
            state   <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
          pp        <= cp;
          pn        <= cn;
          have_prev <= !fin_hold;
        end
        S_MUL: begin
          if (cnt == '0) begin
            for (int k = 0; k < 6; k++) begin
              pacc[k]   <= '0;
              mcand[k]  <= abs_n(nv[NI[k]]);
              mplier[k] <= abs_e(ev[EI[k]]);
            end
            cnt <= MCW'(1);
          end else if (cnt == MCW'(EW + 1)) begin
            for (int i = 0; i < 3; i++) begin
              cr[i] <= prod[2*i] - prod[2*i+1];
            end
            idx   <= '0;
            mmax  <= '0;
            state <= S_NORM;
            cnt   <= '0;
          end else begin
            for (int k = 0; k < 6; k++) begin
              if (mplier[k][0]) pacc[k] <= pacc[k] + mcand[k];
              mcand[k]  <= {mcand[k][PW-2:0], 1'b0};
              mplier[k] <= {1'b0, mplier[k][EW-1:1]};
            end
            cnt <= cnt + MCW'(1);
          end
        end
        S_NORM: begin
          // first magnitudes, then their max; then one bit shift per cycle
          if (cnt == '0) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= cr[i][CW-1];
              mag[i] <= cr[i][CW-1] ? MW'(-cr[i]) : MW'(cr[i]);
            end
            cnt <= MCW'(1);
          end else if (cnt == MCW'(1)) begin
            mmax <= (mag[0] > mag[1]) ? ((mag[0] > mag[2]) ? mag[0] : mag[2])
                                      : ((mag[1] > mag[2]) ? mag[1] : mag[2]);
            cnt  <= MCW'(2);
          end else if (mmax == '0) begin
            deg   <= 1'b1;
            for (int i = 0; i < 3; i++) res[i] <= '0;
            state <= S_OUT;
          end else if (mmax >= MW'(64'd1 << 30)) begin
            mmax <= mmax >> 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (mmax < MW'(64'd1 << 29)) begin
            mmax <= mmax << 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            deg   <= 1'b0;
            l2    <= '0;
            idx   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          l2 <= l2 + MW'(sq);
          if (idx == 2'd2) begin
            rem   <= l2 + MW'(sq);
            root  <= '0;
            bit4  <= MW'(64'd1 << 62);
            state <= S_ROOT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_ROOT: begin
          // bit-pair square root; root ends as the integer square root of the sum
          if (bit4 == '0) begin
            idx   <= '0;
            dnum  <= (mag[0] << 14) + (root >> 1);
            drem  <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            if (rem >= trial) begin
              rem  <= rem - trial;
              root <= (root >> 1) + bit4;
            end else begin
              root <= root >> 1;
            end
            bit4 <= bit4 >> 2;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle over 64 bits
          if (cnt == MCW'(MW)) begin
            res[idx] <= neg[idx] ? OUT_BITS'(-quo) : quo[OUT_BITS-1:0];
            if (idx == 2'd2) begin
              state <= S_OUT;
            end else begin
              idx  <= idx + 2'd1;
              dnum <= (mag[idx + 2'd1] << 14) + (root >> 1);
              drem <= '0;
              quo  <= '0;
              cnt  <= '0;
            end
          end else begin
            if (dsub >= root) begin
              drem <= dsub - root;
              quo  <= {quo[OUT_BITS-1:0], 1'b1};
            end else begin
              drem <= dsub;
              quo  <= {quo[OUT_BITS-1:0], 1'b0};
            end
            dnum <= {dnum[MW-2:0], 1'b0};
            cnt  <= cnt + MCW'(1);
          end
        end
        S_OUT: begin
          if (!ov || out_ready) begin
            obuf.edge_nx     <= res[0];
            obuf.edge_ny     <= res[1];
            obuf.edge_nz     <= res[2];
            obuf.degenerate  <= deg;
            obuf.end_of_line <= cur_eol;
            ov               <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPLN_ASSERT_IMP(a_busy_no_ready, state != S_IDLE, !in_ready, "ready while busy")
  `CPLN_ASSERT_IMP(a_deg_zero, out_valid && out_data.degenerate,
    out_data.edge_nx == '0 && out_data.edge_ny == '0 && out_data.edge_nz == '0,
    "degenerate result not zero")
  `CPLN_ASSERT_NEXT(a_pend_eol, pend_last && state == S_IDLE,
    state == S_MUL && cur_eol, "second result not started")
endmodule

// ----- test/tb_closed_polyline_line_normal_top.sv -----
// testbench for the closed polyline line normal block
module tb_closed_polyline_line_normal_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpln_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  closed_polyline_line_normal_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  longint first_pt[3] = '{0, 0, 0};
  longint pend_pt[3] = '{0, 0, 0};
  longint pend_nrm[3] = '{0, 0, 0};
  bit pend_valid = 1'b0;

  in_item_t point_queue[$];
  out_item_t normal_queue[$];
  int errors = 0;
  int points_sent = 0;
  int normals_seen = 0;
  int degenerate_seen = 0;
  int lines_closed = 0;
  bit idle_enable;
  bit sender_pause;
  bit rx_hold;
  int tx_gap;
  int rx_gap;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t calc_normal(longint ex, longint ey, longint ez,
                                            longint nx, longint ny, longint nz,
                                            bit eol);
    out_item_t res;
    longint c[3];
    longint unsigned mag[3];
    longint unsigned m;
    longint unsigned l2;
    longint unsigned len;
    longint unsigned q;
    int left;
    int right;
    logic [15:0] comp[3];
    c[0] = ey * nz - ez * ny;
    c[1] = ez * nx - ex * nz;
    c[2] = ex * ny - ey * nx;
    m = 0;
    left = 0;
    right = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (mag[i] > m) m = mag[i];
    end
    res = '0;
    res.end_of_line = eol;
    if (m == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      right++;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      left++;
    end
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (mag[i] >> right) << left;
      l2 += mag[i] * mag[i];
    end
    len = root64(l2);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + (len >> 1)) / len;
      if (c[i] < 0) q = -q;
      comp[i] = q[15:0];
    end
    res.edge_nx = comp[0];
    res.edge_ny = comp[1];
    res.edge_nz = comp[2];
    return res;
  endfunction

  task automatic queue_point(in_item_t it);
    point_queue = {point_queue, it};
  endtask

  task automatic queue_normal(out_item_t it);
    normal_queue = {normal_queue, it};
  endtask

  task automatic predict_point(in_item_t it);
    longint p[3];
    longint n[3];
    p[0] = it.point_x;
    p[1] = it.point_y;
    p[2] = it.point_z;
    n[0] = it.surf_nx;
    n[1] = it.surf_ny;
    n[2] = it.surf_nz;
    if (pend_valid) begin
      queue_normal(calc_normal(p[0] - pend_pt[0], p[1] - pend_pt[1],
                               p[2] - pend_pt[2], pend_nrm[0],
                               pend_nrm[1], pend_nrm[2], 1'b0));
    end else begin
      first_pt = p;
    end
    if (it.final_point) begin
      queue_normal(calc_normal(first_pt[0] - p[0], first_pt[1] - p[1],
                               first_pt[2] - p[2], n[0], n[1], n[2],
                               1'b1));
      pend_valid = 1'b0;
      lines_closed++;
    end else begin
      pend_pt = p;
      pend_nrm = n;
      pend_valid = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on normal %0d: %s got %0d expected %0d",
             normals_seen, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_point(in_data);
        points_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the transaction
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        tx_gap <= $urandom_range(1, 12) - 1;
      end else if (!sender_pause && point_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= point_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (normal_queue.size() == 0) begin
          report_mismatch("unexpected normal, pending", 0, 0);
        end else begin
          out_item_t want;
          want = normal_queue.pop_front();
          if (out_data.edge_nx !== want.edge_nx)
            report_mismatch("edge_nx", out_data.edge_nx, want.edge_nx);
          if (out_data.edge_ny !== want.edge_ny)
            report_mismatch("edge_ny", out_data.edge_ny, want.edge_ny);
          if (out_data.edge_nz !== want.edge_nz)
            report_mismatch("edge_nz", out_data.edge_nz, want.edge_nz);
          if (out_data.degenerate !== want.degenerate)
            report_mismatch("degenerate", out_data.degenerate, want.degenerate);
          if (out_data.end_of_line !== want.end_of_line)
            report_mismatch("end_of_line", out_data.end_of_line, want.end_of_line);
          if (want.degenerate) degenerate_seen++;
        end
        normals_seen++;
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        rx_gap <= $urandom_range(1, 12) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_point(int cx, int cy, int cz, int nx, int ny,
                                          int nz, bit fin);
    in_item_t it;
    it.point_x = cx[23:0];
    it.point_y = cy[23:0];
    it.point_z = cz[23:0];
    it.surf_nx = nx[15:0];
    it.surf_ny = ny[15:0];
    it.surf_nz = nz[15:0];
    it.final_point = fin;
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
      1: return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic int rand_normal();
    case ($urandom_range(0, 7))
      0: return $signed($urandom_range(0, 16'hFFFF) << 16) >>> 16;
      1: return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      2: return 0;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // a closed line of n points, most near a random start and some fully random
  task automatic queue_line(int n);
    int bx;
    int by;
    int bz;
    bx = rand_coord();
    by = rand_coord();
    bz = rand_coord();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_point(make_point(rand_coord(), rand_coord(), rand_coord(),
                               rand_normal(), rand_normal(), rand_normal(),
                               i == n - 1));
      else
        queue_point(make_point(bx + int'($urandom_range(0, 600)) - 300,
                               by + int'($urandom_range(0, 600)) - 300,
                               bz + int'($urandom_range(0, 600)) - 300,
                               rand_normal(), rand_normal(), rand_normal(),
                               i == n - 1));
    end
  endtask

  task automatic wait_drained();
    while (point_queue.size() > 0 || in_valid || normal_queue.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    idle_enable = 1'b1;
    sender_pause = 1'b0;
    rx_hold = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: single point lines, extremes, zero edge, zero normal
    queue_point(make_point(5, 6, 7, 16384, 0, 0, 1'b1));
    queue_point(make_point(8388607, 8388607, 8388607, 16384, 0, 0, 1'b0));
    queue_point(make_point(-8388608, -8388608, -8388608, 0, 16384, 0, 1'b0));
    queue_point(make_point(8388607, -8388608, 0, -16384, -16384, 16384, 1'b1));
    queue_point(make_point(0, 0, 0, 0, 0, 16384, 1'b0));
    queue_point(make_point(0, 0, 0, 0, 0, 16384, 1'b0));
    queue_point(make_point(65536, 0, 0, 16384, 0, 0, 1'b0));
    queue_point(make_point(65536, 65536, 0, 0, 0, 0, 1'b1));
    queue_point(make_point(1, 0, 0, -32768, 32767, -1, 1'b0));
    queue_point(make_point(0, 1, 0, 32767, -32768, 1, 1'b0));
    queue_point(make_point(-1, -1, 1, 16384, 16384, 16384, 1'b1));
    queue_point(make_point(-8388608, 8388607, -8388608, -32768, -32768,
                           -32768, 1'b1));
    queue_point(make_point(100, 200, 300, 0, 16384, 0, 1'b0));
    queue_point(make_point(100, 200, 300, 0, 16384, 0, 1'b1));
    wait_drained();

    // long receiver stall while the sender keeps offering
    queue_line(20);
    rx_hold = 1'b1;
    repeat (3000) @(posedge clk);
    rx_hold = 1'b0;
    wait_drained();

    // sender pause until all expected normals have come
    queue_line(6);
    while (points_sent < 3) @(posedge clk);
    sender_pause = 1'b1;
    while (in_valid || normal_queue.size() > 0) @(posedge clk);
    sender_pause = 1'b0;
    wait_drained();

    while (points_sent < 1000) begin
      queue_line($urandom_range(1, 12));
      wait_drained();
    end
    idle_enable = 1'b0;
    while (points_sent < 1250) begin
      queue_line($urandom_range(1, 12));
      wait_drained();
    end
    repeat (600) @(posedge clk);

    $display("sent %0d points in %0d closed lines, checked %0d normals (%0d degenerate)",
             points_sent, lines_closed, normals_seen, degenerate_seen);
    if (errors == 0 && normal_queue.size() == 0) begin
      $display("closed_polyline_line_normal_top regression: pass");
    end else begin
      $display("closed_polyline_line_normal_top regression: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout waiting for the block");
    $display("closed_polyline_line_normal_top regression: fail");
    $finish;
  end
endmodule
